// ----- sv/tdrm_pkg.sv -----
package tdrm_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);

  localparam int MASK_W = 64;
  localparam int FILT_W = 6;
  localparam int PT_W = 16;
  localparam int ETA_W = 12;
  localparam int PHI_W = 11;
  localparam int ENTRY_W = FILT_W + PT_W + ETA_W + PHI_W;

  localparam int PT_TOL_W = 8;
  localparam int DR_LIM_W = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [PT_TOL_W-1:0] PT_TOL_RESET = 8'd26;
  localparam logic [DR_LIM_W-1:0] DR_LIM_RESET = 10'd26;

  // phi units of 1/256 rad
  localparam logic signed [12:0] PHI_PI = 13'sd804;
  localparam logic signed [12:0] PHI_TWO_PI = 13'sd1608;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_STORE = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PT_TOL = 2'd0,
    CFG_DR_LIMIT = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // layout of one store entry, filter index in the lowest bits
  typedef struct packed {
    logic signed [PHI_W-1:0] phi;
    logic signed [ETA_W-1:0] eta;
    logic [PT_W-1:0] pt;
    logic [FILT_W-1:0] filter_index;
  } obj_t;

endpackage

// ----- sv/tdrm_ram.sv -----
module tdrm_ram #(
  parameter int WIDTH = 45,
  parameter int DEPTH = 64,
  parameter int AddrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AddrWidth-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [AddrWidth-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/trigger_object_delta_r_matcher_core.sv -----
// store, clear and unused commands: the result is loaded from the finish state after the
// input transfer, and the next input is taken back in idle; query: the result follows the scan
// and the pipeline drain, and the next input is taken once it is loaded; a held result stalls
// a query reads the object memory one entry per cycle into a three-stage compare pipeline
// reset (rst, synchronous) empties the store count and sets pt_tolerance and dr_limit
// to 26; memory contents are left as they are, no clearing pass
module trigger_object_delta_r_matcher_core
  import tdrm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [47:0]           s_tdata,   // filter_index, pt, eta, phi, zero fill
  input  logic [1:0]            s_tuser,   // command
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [MASK_W-1:0]     m_tdata,   // match_mask
  output logic [0:0]            m_tuser,   // status
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t state, state_next;

  logic [PT_TOL_W-1:0] pt_tolerance;
  logic [DR_LIM_W-1:0] dr_limit;
  logic [2*DR_LIM_W-1:0] lim_sq;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] rd_ptr;
  logic store_full;

  logic accept;
  logic out_load;
  logic rd_en;
  logic scan_done;
  logic [1:0] cmd_in;
  obj_t obj_in;

  // query operand
  logic [PT_W-1:0] q_pt;
  logic signed [ETA_W-1:0] q_eta;
  logic signed [PHI_W-1:0] q_phi;

  logic [MASK_W-1:0] mask;
  logic status;

  logic [ENTRY_W-1:0] rd_data;
  obj_t rd_obj;

  logic v0, v1, v2;

  // stage 1: differences
  logic signed [12:0] de_c;
  logic signed [12:0] dp_raw_c;
  logic signed [12:0] dp_c;
  logic [11:0] ade_c;
  logic [11:0] adp_c;
  logic [PT_W-1:0] dpt_c;

  logic [FILT_W-1:0] s1_filt;
  logic [PT_W-1:0] s1_opt;
  logic [PT_W-1:0] s1_dpt;
  logic [11:0] s1_ade;
  logic [11:0] s1_adp;

  // stage 2: products
  logic [FILT_W-1:0] s2_filt;
  logic [23:0] s2_de2;
  logic [23:0] s2_dp2;
  logic [23:0] s2_tolpt;
  logic [23:0] s2_dpt256;
  logic s2_match;

  assign cmd_in = s_tuser;
  assign obj_in = obj_t'(s_tdata[ENTRY_W-1:0]);
  assign accept = s_tvalid && s_tready;
  assign store_full = (count >= CNT_W'(STORE_DEPTH));
  assign rd_obj = obj_t'(rd_data);

  tdrm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (accept && (cmd_in == CMD_STORE) && !store_full),
    .waddr(count[ADDR_W-1:0]),
    .wdata(ENTRY_W'(obj_in)),
    .re   (rd_en),
    .raddr(rd_ptr[ADDR_W-1:0]),
    .rdata(rd_data)
  );

  assign scan_done = (rd_ptr >= count) && !v0 && !v1 && !v2;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (cmd_in == CMD_QUERY) ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    out_load = 1'b0;
    rd_en = 1'b0;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_SCAN: rd_en = (rd_ptr < count);
      ST_FINISH: out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_comb begin
    de_c = {q_eta[ETA_W-1], q_eta} - {rd_obj.eta[ETA_W-1], rd_obj.eta};
    dp_raw_c = 13'({{2{q_phi[PHI_W-1]}}, q_phi}) - 13'({{2{rd_obj.phi[PHI_W-1]}}, rd_obj.phi});
    // single wrap toward plus or minus pi
    dp_c = dp_raw_c;
    if (dp_raw_c > PHI_PI) begin
      dp_c = dp_raw_c - PHI_TWO_PI;
    end else if (dp_raw_c < -PHI_PI) begin
      dp_c = dp_raw_c + PHI_TWO_PI;
    end
    ade_c = de_c[12] ? 12'(-de_c) : de_c[11:0];
    adp_c = dp_c[12] ? 12'(-dp_c) : dp_c[11:0];
    dpt_c = (q_pt >= rd_obj.pt) ? (q_pt - rd_obj.pt) : (rd_obj.pt - q_pt);
  end

  assign s2_match = (s2_dpt256 < s2_tolpt) && ((25'(s2_de2) + 25'(s2_dp2)) < 25'(lim_sq));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      m_tvalid <= 1'b0;
      pt_tolerance <= PT_TOL_RESET;
      dr_limit <= DR_LIM_RESET;
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_PT_TOL: pt_tolerance <= cfg_data[PT_TOL_W-1:0];
          CFG_DR_LIMIT: dr_limit <= cfg_data[DR_LIM_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (cmd_in == CMD_CLEAR) begin
          count <= '0;
        end else if ((cmd_in == CMD_STORE) && !store_full) begin
          count <= count + 1'b1;
        end
      end
      v0 <= rd_en;
      v1 <= v0;
      v2 <= v1;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lim_sq <= {{DR_LIM_W{1'b0}}, dr_limit} * {{DR_LIM_W{1'b0}}, dr_limit};

    if (accept) begin
      q_pt <= obj_in.pt;
      q_eta <= obj_in.eta;
      q_phi <= obj_in.phi;
      mask <= '0;
      status <= (cmd_in == CMD_STORE) && store_full;
      rd_ptr <= '0;
    end else begin
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (v2 && s2_match) begin
        mask <= mask | (MASK_W'(1) << s2_filt);
      end
    end

    s1_filt <= rd_obj.filter_index;
    s1_opt <= rd_obj.pt;
    s1_dpt <= dpt_c;
    s1_ade <= ade_c;
    s1_adp <= adp_c;

    s2_filt <= s1_filt;
    s2_de2 <= {12'd0, s1_ade} * {12'd0, s1_ade};
    s2_dp2 <= {12'd0, s1_adp} * {12'd0, s1_adp};
    s2_tolpt <= {16'd0, pt_tolerance} * {8'd0, s1_opt};
    s2_dpt256 <= {s1_dpt, 8'd0};

    if (out_load) begin
      m_tdata <= mask;
      m_tuser <= status;
    end
  end

endmodule

// ----- verif/trigger_object_delta_r_matcher_core_test.sv -----
module trigger_object_delta_r_matcher_core_test;
  import tdrm_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 1550;
  localparam int MAX_REPORTS = 10;
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic              status;
  } verdict_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [47:0]           s_tdata = '0;
  logic [1:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [MASK_W-1:0]     m_tdata;
  logic [0:0]            m_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state
  obj_t                  trig_mem [STORE_DEPTH];
  int                    trig_cnt;
  logic [PT_TOL_W-1:0]   tol_reg;
  logic [DR_LIM_W-1:0]   drl_reg;
  verdict_t              due_q [$];

  int mism_cnt = 0;
  int items_sent = 0;
  int burst_left = 0;
  bit sender_nogap = 1'b0;
  bit holdoff_req = 1'b0;
  int rx_mode = 0;
  int rx_span = 0;
  int rx_phase = 0;
  int idle_cycles = 0;

  trigger_object_delta_r_matcher_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int clip(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit obj_hit(obj_t o, obj_t q);
    longint dpt, de, dp, lim;
    dpt = longint'(q.pt) - longint'(o.pt);
    if (dpt < 0) dpt = -dpt;
    if (dpt * 256 >= longint'(tol_reg) * longint'(o.pt)) return 1'b0;
    de = longint'($signed(q.eta)) - longint'($signed(o.eta));
    dp = longint'($signed(q.phi)) - longint'($signed(o.phi));
    // single wrap toward plus or minus pi
    if (dp > longint'(PHI_PI)) dp -= longint'(PHI_TWO_PI);
    if (dp < -longint'(PHI_PI)) dp += longint'(PHI_TWO_PI);
    lim = longint'(drl_reg);
    return (de * de + dp * dp) < (lim * lim);
  endfunction

  function automatic verdict_t run_matcher(logic [1:0] cmd, obj_t f);
    verdict_t v;
    v = '0;
    case (cmd)
      CMD_CLEAR: trig_cnt = 0;
      CMD_STORE: begin
        if (trig_cnt < STORE_DEPTH) begin
          trig_mem[trig_cnt] = f;
          trig_cnt++;
        end else begin
          v.status = 1'b1;
        end
      end
      CMD_QUERY: begin
        for (int i = 0; i < trig_cnt; i++) begin
          if (obj_hit(trig_mem[i], f)) v.mask[trig_mem[i].filter_index] = 1'b1;
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  // entered and left at a falling edge
  task automatic send_item(input logic [1:0] cmd, input int filt, input int pt,
                           input int eta, input int phi);
    obj_t f;
    f.filter_index = filt[FILT_W-1:0];
    f.pt = pt[PT_W-1:0];
    f.eta = eta[ETA_W-1:0];
    f.phi = phi[PHI_W-1:0];
    if (!sender_nogap && burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    if (burst_left > 0) burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {{(48 - ENTRY_W){1'b0}}, f};
    s_tuser <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    due_q.insert(due_q.size(), run_matcher(cmd, f));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_item(input logic [1:0] cmd);
    int filt, pt, eta, phi, pick;
    filt = $urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom_range(0, 3);
    pick = $urandom_range(0, 9);
    if (pick == 0) pt = $urandom_range(0, 65535);
    else if (pick == 1) pt = $urandom_range(0, 15);
    else pt = $urandom_range(16, 8000);
    if ($urandom_range(0, 4) == 0) eta = int'($urandom_range(0, 4095)) - 2048;
    else eta = int'($urandom_range(0, 1280)) - 640;
    if ($urandom_range(0, 6) == 0) phi = int'($urandom_range(0, 2047)) - 1024;
    else phi = int'($urandom_range(0, 1608)) - 804;
    send_item(cmd, filt, pt, eta, phi);
  endtask

  // query placed around a stored object so that both tests sit near their limits
  task automatic send_near_query();
    obj_t o;
    int span, r, pt, eta, phi;
    if (trig_cnt == 0) begin
      send_random_item(CMD_QUERY);
    end else begin
      o = trig_mem[$urandom_range(0, trig_cnt - 1)];
      span = (int'(o.pt) * int'(tol_reg)) / 256 + 2;
      r = int'(drl_reg) + 2;
      pt = clip(int'(o.pt) + int'($urandom_range(0, 2 * span)) - span, 0, 65535);
      eta = clip(int'($signed(o.eta)) + int'($urandom_range(0, 2 * r)) - r, -2048, 2047);
      phi = int'($signed(o.phi)) + int'($urandom_range(0, 2 * r)) - r;
      if (phi > 804 && $urandom_range(0, 1)) phi -= 1608;
      if (phi < -804 && $urandom_range(0, 1)) phi += 1608;
      phi = clip(phi, -1024, 1023);
      send_item(CMD_QUERY, $urandom_range(0, 63), pt, eta, phi);
    end
  endtask

  task automatic wait_drain(input int settle);
    s_tvalid <= 1'b0;
    while (due_q.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PT_TOL) tol_reg = val[PT_TOL_W-1:0];
    else if (idx == CFG_DR_LIMIT) drl_reg = val;
    @(negedge clk);
  endtask

  task automatic set_config(input int tol, input int drl);
    wait_drain(4);
    write_cfg(CFG_PT_TOL, tol[CFG_DATA_W-1:0]);
    write_cfg(CFG_DR_LIMIT, drl[CFG_DATA_W-1:0]);
  endtask

  task automatic test_directed();
    send_item(CMD_QUERY, 0, 1600, 0, 0);
    send_item(CMD_SPARE, 63, 65535, 2047, 1023);
    send_item(CMD_STORE, 0, 1600, 0, 0);
    send_item(CMD_STORE, 63, 65535, 2047, 1023);
    send_item(CMD_STORE, 5, 0, 100, 100);
    send_item(CMD_STORE, 10, 800, -2048, -804);
    send_item(CMD_STORE, 20, 1000, 300, 800);
    send_item(CMD_STORE, 33, 1, -1, -1024);
    send_item(CMD_QUERY, 0, 1600, 0, 0);
    // zero pt object can never match
    send_item(CMD_QUERY, 0, 0, 100, 100);
    send_item(CMD_QUERY, 0, 65535, 2047, 1023);
    // phi difference wraps in both directions
    send_item(CMD_QUERY, 0, 1000, 300, -800);
    send_item(CMD_QUERY, 0, 800, -2048, 804);
    // angular and pt limits, just at or past and just inside
    send_item(CMD_QUERY, 0, 1600, 26, 0);
    send_item(CMD_QUERY, 0, 1600, 25, 0);
    send_item(CMD_QUERY, 0, 1762, 0, 0);
    send_item(CMD_QUERY, 0, 1763, 0, 0);
    send_item(CMD_QUERY, 0, 1, -1, -1024);
    send_item(CMD_CLEAR, 63, 65535, -1, -1);
    send_item(CMD_QUERY, 0, 1600, 0, 0);
    send_item(CMD_STORE, 42, 1600, 0, 0);
    send_item(CMD_QUERY, 0, 1600, 0, 0);
  endtask

  task automatic test_config_regs();
    int tols [5] = '{0, 255, 1023, 0, 128};
    int drls [5] = '{1023, 0, 1023, 0, 60};
    wait_drain(4);
    send_item(CMD_CLEAR, 0, 0, 0, 0);
    send_item(CMD_STORE, 1, 2000, 0, 0);
    send_item(CMD_STORE, 2, 2000, 40, 30);
    send_item(CMD_STORE, 3, 100, -500, 790);
    send_item(CMD_STORE, 4, 40000, 1000, -700);
    for (int k = 0; k < 5; k++) begin
      set_config(tols[k], drls[k]);
      send_item(CMD_QUERY, 0, 2000, 0, 0);
      send_item(CMD_QUERY, 0, 2100, 20, 10);
      send_item(CMD_QUERY, 0, 100, -500, -800);
      send_item(CMD_QUERY, 0, 40000, 1000, -700);
      send_item(CMD_QUERY, 0, 30000, 900, -760);
    end
    // writes to unused indexes must leave both limits alone
    wait_drain(4);
    write_cfg(CFG_SPARE_LO, 10'h000);
    write_cfg(CFG_SPARE_HI, 10'h3FF);
    send_item(CMD_QUERY, 0, 2000, 0, 0);
    send_item(CMD_QUERY, 0, 2050, 35, 25);
  endtask

  task automatic test_random_traffic();
    int start, nobj, nq, pick, tol, drl;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      tol = (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(8, 80);
      pick = $urandom_range(0, 9);
      if (pick == 0) drl = 0;
      else if (pick == 1) drl = 1023;
      else if (pick == 2) drl = $urandom_range(0, 1023);
      else drl = $urandom_range(8, 200);
      set_config(tol, drl);
      sender_nogap = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 7) nobj = $urandom_range(1, 12);
      else if (pick < 9) nobj = $urandom_range(13, 63);
      else nobj = $urandom_range(64, 70);
      send_random_item(CMD_CLEAR);
      repeat (nobj) begin
        if ($urandom_range(0, 19) == 0)
          send_random_item($urandom_range(0, 1) ? CMD_QUERY : CMD_SPARE);
        else
          send_random_item(CMD_STORE);
      end
      nq = $urandom_range(4, 16);
      repeat (nq) begin
        pick = $urandom_range(0, 19);
        if (pick < 15) send_near_query();
        else if (pick < 18) send_random_item(CMD_QUERY);
        else send_random_item(2'($urandom_range(0, 3)));
      end
    end
    sender_nogap = 1'b0;
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    wait_drain(4);
    sender_nogap = 1'b1;
    send_random_item(CMD_CLEAR);
    repeat (8) send_random_item(CMD_STORE);
    holdoff_req = 1'b1;
    repeat (16) begin
      if ($urandom_range(0, 3) == 0) send_random_item(CMD_STORE);
      else send_near_query();
    end
    sender_nogap = 1'b0;
    wait_drain(4);
  endtask

  // receiver stall pattern
  initial begin
    forever begin
      @(negedge clk);
      if (holdoff_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holdoff_req = 1'b0;
        m_tready <= 1'b1;
      end else begin
        if (rx_span == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_span = $urandom_range(20, 300);
          rx_phase = 0;
        end
        rx_span--;
        rx_phase++;
        case (rx_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 99) < 60);
          2: m_tready <= ((rx_phase % 7) < 3);
          default: m_tready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    verdict_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (due_q.size() == 0) begin
        mism_cnt++;
        if (mism_cnt <= MAX_REPORTS)
          $display("unexpected transfer: mask %h status %0d", m_tdata, m_tuser);
      end else begin
        want = due_q.pop_front();
        if (m_tdata !== want.mask || m_tuser[0] !== want.status) begin
          mism_cnt++;
          if (mism_cnt <= MAX_REPORTS)
            $display("mismatch: mask exp %h got %h, status exp %0d got %0d",
                     want.mask, m_tdata, want.status, m_tuser);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    trig_cnt = 0;
    tol_reg = PT_TOL_RESET;
    drl_reg = DR_LIM_RESET;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_config_regs();
    test_random_traffic();
    test_backpressure();
    wait_drain(12);
    if (mism_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
